@@ rtl/core/vrp_pkg.sv @@
// Shared types, constants and helper functions for the vertex rotate and project block.
package vrp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_ANGLE_A      = 3'd0;
    localparam logic [2:0] REG_ANGLE_B      = 3'd1;
    localparam logic [2:0] REG_DEPTH_OFFSET = 3'd2;
    localparam logic [2:0] REG_CENTER_X     = 3'd3;
    localparam logic [2:0] REG_CENTER_Y     = 3'd4;

    // The cosine of an angle sits a quarter turn further on in the sine table.
    localparam logic [7:0] COS_OFFSET = 8'd64;

    // Fixed part of the depth bias.
    localparam logic [9:0] DEPTH_BASE = 10'h080;

    // One input vertex.
    typedef struct packed {
        logic signed [7:0] vx;
        logic signed [7:0] vy;
        logic signed [7:0] vz;
        logic              last_vertex;
    } vertex_t;

    // One projected screen point.
    typedef struct packed {
        logic [7:0] screen_x;
        logic [7:0] screen_y;
        logic       last_point;
    } point_t;

    // Rotation coefficients and screen settings derived from the configuration.
    typedef struct packed {
        logic signed [7:0] sa;
        logic signed [7:0] ca;
        logic signed [7:0] sb;
        logic signed [7:0] cb;
        logic signed [7:0] e0;
        logic signed [7:0] e1;
        logic signed [7:0] e2;
        logic signed [7:0] e3;
        logic [9:0]        bias;
        logic [7:0]        center_x;
        logic [7:0]        center_y;
    } coef_t;

    // Rotated vertex: two numerators and the shared divisor, all modulo 2^16.
    typedef struct packed {
        logic [15:0] f0;
        logic [15:0] f1;
        logic [15:0] f2;
        logic        last;
    } xf_t;

    // Low byte of each quotient magnitude with the signs and the zero divisor flag.
    typedef struct packed {
        logic [7:0] qx;
        logic [7:0] qy;
        logic       neg_x;
        logic       neg_y;
        logic       zero;
        logic       last;
    } quo_t;

    // One full period of the sine, scaled to plus or minus 64.
    localparam logic signed [7:0] SINE_TABLE [256] = '{
        8'sd0, 8'sd2, 8'sd3, 8'sd5, 8'sd6, 8'sd8, 8'sd9, 8'sd11,
        8'sd12, 8'sd14, 8'sd16, 8'sd17, 8'sd19, 8'sd20, 8'sd22, 8'sd23,
        8'sd24, 8'sd26, 8'sd27, 8'sd29, 8'sd30, 8'sd32, 8'sd33, 8'sd34,
        8'sd36, 8'sd37, 8'sd38, 8'sd39, 8'sd41, 8'sd42, 8'sd43, 8'sd44,
        8'sd45, 8'sd46, 8'sd47, 8'sd48, 8'sd49, 8'sd50, 8'sd51, 8'sd52,
        8'sd53, 8'sd54, 8'sd55, 8'sd56, 8'sd56, 8'sd57, 8'sd58, 8'sd59,
        8'sd59, 8'sd60, 8'sd60, 8'sd61, 8'sd61, 8'sd62, 8'sd62, 8'sd62,
        8'sd63, 8'sd63, 8'sd63, 8'sd64, 8'sd64, 8'sd64, 8'sd64, 8'sd64,
        8'sd64, 8'sd64, 8'sd64, 8'sd64, 8'sd64, 8'sd64, 8'sd63, 8'sd63,
        8'sd63, 8'sd62, 8'sd62, 8'sd62, 8'sd61, 8'sd61, 8'sd60, 8'sd60,
        8'sd59, 8'sd59, 8'sd58, 8'sd57, 8'sd56, 8'sd56, 8'sd55, 8'sd54,
        8'sd53, 8'sd52, 8'sd51, 8'sd50, 8'sd49, 8'sd48, 8'sd47, 8'sd46,
        8'sd45, 8'sd44, 8'sd43, 8'sd42, 8'sd41, 8'sd39, 8'sd38, 8'sd37,
        8'sd36, 8'sd34, 8'sd33, 8'sd32, 8'sd30, 8'sd29, 8'sd27, 8'sd26,
        8'sd24, 8'sd23, 8'sd22, 8'sd20, 8'sd19, 8'sd17, 8'sd16, 8'sd14,
        8'sd12, 8'sd11, 8'sd9, 8'sd8, 8'sd6, 8'sd5, 8'sd3, 8'sd2,
        8'sd0, -8'sd2, -8'sd3, -8'sd5, -8'sd6, -8'sd8, -8'sd9, -8'sd11,
        -8'sd12, -8'sd14, -8'sd16, -8'sd17, -8'sd19, -8'sd20, -8'sd22, -8'sd23,
        -8'sd24, -8'sd26, -8'sd27, -8'sd29, -8'sd30, -8'sd32, -8'sd33, -8'sd34,
        -8'sd36, -8'sd37, -8'sd38, -8'sd39, -8'sd41, -8'sd42, -8'sd43, -8'sd44,
        -8'sd45, -8'sd46, -8'sd47, -8'sd48, -8'sd49, -8'sd50, -8'sd51, -8'sd52,
        -8'sd53, -8'sd54, -8'sd55, -8'sd56, -8'sd56, -8'sd57, -8'sd58, -8'sd59,
        -8'sd59, -8'sd60, -8'sd60, -8'sd61, -8'sd61, -8'sd62, -8'sd62, -8'sd62,
        -8'sd63, -8'sd63, -8'sd63, -8'sd64, -8'sd64, -8'sd64, -8'sd64, -8'sd64,
        -8'sd64, -8'sd64, -8'sd64, -8'sd64, -8'sd64, -8'sd64, -8'sd63, -8'sd63,
        -8'sd63, -8'sd62, -8'sd62, -8'sd62, -8'sd61, -8'sd61, -8'sd60, -8'sd60,
        -8'sd59, -8'sd59, -8'sd58, -8'sd57, -8'sd56, -8'sd56, -8'sd55, -8'sd54,
        -8'sd53, -8'sd52, -8'sd51, -8'sd50, -8'sd49, -8'sd48, -8'sd47, -8'sd46,
        -8'sd45, -8'sd44, -8'sd43, -8'sd42, -8'sd41, -8'sd39, -8'sd38, -8'sd37,
        -8'sd36, -8'sd34, -8'sd33, -8'sd32, -8'sd30, -8'sd29, -8'sd27, -8'sd26,
        -8'sd24, -8'sd23, -8'sd22, -8'sd20, -8'sd19, -8'sd17, -8'sd16, -8'sd14,
        -8'sd12, -8'sd11, -8'sd9, -8'sd8, -8'sd6, -8'sd5, -8'sd3, -8'sd2
    };

    // Full signed product of two 8-bit values.
    function automatic logic signed [15:0] smul8(input logic signed [7:0] a,
                                                 input logic signed [7:0] b);
        logic signed [15:0] a_ext;
        logic signed [15:0] b_ext;
        a_ext = {{8{a[7]}}, a};
        b_ext = {{8{b[7]}}, b};
        return a_ext * b_ext;
    endfunction

endpackage

@@ rtl/core/vrp_coef.sv @@
// Configuration registers and the rotation coefficients derived from them.
module vrp_coef
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output vrp_pkg::coef_t      coef
);

    // Product term: floor(a*b/256)*4; the true value lies within plus or minus 64.
    function automatic logic signed [7:0] e_term(input logic signed [7:0] a,
                                                 input logic signed [7:0] b);
        logic signed [15:0] p;
        p = vrp_pkg::smul8(a, b);
        return {p[13:8], 2'b00};
    endfunction

    logic [7:0] angle_a_reg;
    logic [7:0] angle_b_reg;
    logic [7:0] depth_reg;
    logic [7:0] center_x_reg;
    logic [7:0] center_y_reg;

    logic signed [7:0] sa_reg;
    logic signed [7:0] ca_reg;
    logic signed [7:0] sb_reg;
    logic signed [7:0] cb_reg;
    logic signed [7:0] e0_reg;
    logic signed [7:0] e1_reg;
    logic signed [7:0] e2_reg;
    logic signed [7:0] e3_reg;
    logic [9:0]        bias_reg;
    logic [9:0]        bias_next;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_a_reg  <= 8'd0;
            angle_b_reg  <= 8'd0;
            depth_reg    <= 8'd0;
            center_x_reg <= 8'd0;
            center_y_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                vrp_pkg::REG_ANGLE_A:      angle_a_reg  <= cfg_data;
                vrp_pkg::REG_ANGLE_B:      angle_b_reg  <= cfg_data;
                vrp_pkg::REG_DEPTH_OFFSET: depth_reg    <= cfg_data;
                vrp_pkg::REG_CENTER_X:     center_x_reg <= cfg_data;
                vrp_pkg::REG_CENTER_Y:     center_y_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign bias_next = {1'b0, depth_reg, 1'b0} + vrp_pkg::DEPTH_BASE;

    // Sine and cosine lookups, then the product terms from the registered lookups.
    // Reset values are those of both angles at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg   <= vrp_pkg::SINE_TABLE[0];
            ca_reg   <= vrp_pkg::SINE_TABLE[vrp_pkg::COS_OFFSET];
            sb_reg   <= vrp_pkg::SINE_TABLE[0];
            cb_reg   <= vrp_pkg::SINE_TABLE[vrp_pkg::COS_OFFSET];
            e0_reg   <= e_term(vrp_pkg::SINE_TABLE[0], vrp_pkg::SINE_TABLE[0]);
            e1_reg   <= e_term(vrp_pkg::SINE_TABLE[vrp_pkg::COS_OFFSET],
                               vrp_pkg::SINE_TABLE[vrp_pkg::COS_OFFSET]);
            e2_reg   <= e_term(vrp_pkg::SINE_TABLE[vrp_pkg::COS_OFFSET],
                               vrp_pkg::SINE_TABLE[0]);
            e3_reg   <= e_term(vrp_pkg::SINE_TABLE[0],
                               vrp_pkg::SINE_TABLE[vrp_pkg::COS_OFFSET]);
            bias_reg <= vrp_pkg::DEPTH_BASE;
        end
        else
        begin
            sa_reg   <= vrp_pkg::SINE_TABLE[angle_a_reg];
            ca_reg   <= vrp_pkg::SINE_TABLE[angle_a_reg + vrp_pkg::COS_OFFSET];
            sb_reg   <= vrp_pkg::SINE_TABLE[angle_b_reg];
            cb_reg   <= vrp_pkg::SINE_TABLE[angle_b_reg + vrp_pkg::COS_OFFSET];
            e0_reg   <= e_term(sb_reg, sa_reg);
            e1_reg   <= e_term(cb_reg, ca_reg);
            e2_reg   <= e_term(cb_reg, sa_reg);
            e3_reg   <= e_term(sb_reg, ca_reg);
            bias_reg <= bias_next;
        end
    end

    assign coef.sa       = sa_reg;
    assign coef.ca       = ca_reg;
    assign coef.sb       = sb_reg;
    assign coef.cb       = cb_reg;
    assign coef.e0       = e0_reg;
    assign coef.e1       = e1_reg;
    assign coef.e2       = e2_reg;
    assign coef.e3       = e3_reg;
    assign coef.bias     = bias_reg;
    assign coef.center_x = center_x_reg;
    assign coef.center_y = center_y_reg;

endmodule

@@ rtl/core/vrp_xform.sv @@
// Four-stage rotation pipeline: forms the two numerators and the depth divisor.
module vrp_xform
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vrp_pkg::vertex_t    in_data,
    input  vrp_pkg::coef_t      coef,
    output logic                out_valid,
    input  logic                out_ready,
    output vrp_pkg::xf_t        out_data
);

    localparam int NSTAGE = 4;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] rdy;

    // Stage 1: captured vertex.
    vrp_pkg::vertex_t vtx_reg;

    // Stage 2: products with the plain sines and cosines.
    logic signed [15:0] cbz_full;
    logic signed [15:0] sbx_full;
    logic signed [15:0] cay_full;
    logic signed [15:0] say_full;
    logic signed [14:0] cbz_reg;
    logic signed [14:0] sbx_reg;
    logic signed [14:0] cay_reg;
    logic signed [14:0] say_reg;
    logic signed [7:0]  x2_reg;
    logic signed [7:0]  z2_reg;
    logic               last2_reg;

    // Stage 3: products with the combined terms, first numerator done.
    logic signed [15:0] e0z_full;
    logic signed [15:0] e2x_full;
    logic signed [15:0] e3z_full;
    logic signed [15:0] e1x_full;
    logic [15:0]        f0_next;
    logic [15:0]        f0_reg;
    logic signed [14:0] e0z_reg;
    logic signed [14:0] cay3_reg;
    logic signed [14:0] e2x_reg;
    logic signed [6:0]  e3z_sh_reg;
    logic signed [6:0]  say_sh_reg;
    logic signed [6:0]  e1x_sh_reg;
    logic               last3_reg;

    // Stage 4: output numerators and divisor.
    logic [15:0]  f1_next;
    logic [15:0]  f2_next;
    vrp_pkg::xf_t xf_reg;

    // A stage can load when it is empty or its contents move on.
    always_comb
    begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign cbz_full = vrp_pkg::smul8(vtx_reg.vz, coef.cb);
    assign sbx_full = vrp_pkg::smul8(vtx_reg.vx, coef.sb);
    assign cay_full = vrp_pkg::smul8(vtx_reg.vy, coef.ca);
    assign say_full = vrp_pkg::smul8(vtx_reg.vy, coef.sa);

    assign e0z_full = vrp_pkg::smul8(z2_reg, coef.e0);
    assign e2x_full = vrp_pkg::smul8(x2_reg, coef.e2);
    assign e3z_full = vrp_pkg::smul8(z2_reg, coef.e3);
    assign e1x_full = vrp_pkg::smul8(x2_reg, coef.e1);

    assign f0_next = {cbz_reg[14], cbz_reg} - {sbx_reg[14], sbx_reg};

    assign f1_next = {e0z_reg[14], e0z_reg} + {cay3_reg[14], cay3_reg}
                   + {e2x_reg[14], e2x_reg};

    // The shifted terms are already floored by dropping the low eight bits.
    assign f2_next = {{9{e3z_sh_reg[6]}}, e3z_sh_reg} - {{9{say_sh_reg[6]}}, say_sh_reg}
                   + {{9{e1x_sh_reg[6]}}, e1x_sh_reg} + {6'd0, coef.bias};

    // Data registers of the four stages.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            vtx_reg <= in_data;
        end
        if (rdy[1])
        begin
            cbz_reg   <= cbz_full[14:0];
            sbx_reg   <= sbx_full[14:0];
            cay_reg   <= cay_full[14:0];
            say_reg   <= say_full[14:0];
            x2_reg    <= vtx_reg.vx;
            z2_reg    <= vtx_reg.vz;
            last2_reg <= vtx_reg.last_vertex;
        end
        if (rdy[2])
        begin
            f0_reg     <= f0_next;
            e0z_reg    <= e0z_full[14:0];
            cay3_reg   <= cay_reg;
            e2x_reg    <= e2x_full[14:0];
            e3z_sh_reg <= e3z_full[14:8];
            say_sh_reg <= say_reg[14:8];
            e1x_sh_reg <= e1x_full[14:8];
            last3_reg  <= last2_reg;
        end
        if (rdy[3])
        begin
            xf_reg.f0   <= f0_reg;
            xf_reg.f1   <= f1_next;
            xf_reg.f2   <= f2_next;
            xf_reg.last <= last3_reg;
        end
    end

    assign out_valid = v_reg[NSTAGE-1];
    assign out_data  = xf_reg;

endmodule

@@ rtl/core/vrp_divide.sv @@
// Six-stage projection divider: sign split, divisor scaling and two lanes of division.
module vrp_divide
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vrp_pkg::xf_t        in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vrp_pkg::quo_t       out_data
);

    localparam int QBITS     = 16;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGE = QBITS / DIV_STEPS;
    localparam int NSTAGE    = DIV_STAGE + 2;

    // Partial division state of both lanes.
    typedef struct packed {
        logic [7:0]  rem0;
        logic [15:0] dq0;
        logic [7:0]  rem1;
        logic [15:0] dq1;
        logic [7:0]  den;
        logic        neg0;
        logic        neg1;
        logic        zero;
        logic        last;
    } dstage_t;

    // Several restoring division steps: dividend bits leave the top of dq,
    // quotient bits enter at the bottom.
    function automatic logic [23:0] div_steps(input logic [7:0]  rem_in,
                                              input logic [15:0] dq_in,
                                              input logic [7:0]  den);
        logic [7:0]  rem;
        logic [15:0] dq;
        logic [8:0]  trial;
        logic        qbit;
        rem = rem_in;
        dq  = dq_in;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial = {rem, dq[15]};
            qbit  = (trial >= {1'b0, den});
            if (qbit)
            begin
                rem = 8'(trial - {1'b0, den});
            end
            else
            begin
                rem = trial[7:0];
            end
            dq = {dq[14:0], qbit};
        end
        return {rem, dq};
    endfunction

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] rdy;

    // First stage: sign and magnitude, divisor scale.
    logic [15:0] mag0_next;
    logic [15:0] mag1_next;
    logic [3:0]  sh_next;
    logic [15:0] mag0_reg;
    logic [15:0] mag1_reg;
    logic [15:0] den_reg;
    logic [3:0]  sh_reg;
    logic        neg0_reg;
    logic        neg1_reg;
    logic        zero_reg;
    logic        last_reg;

    // Second stage onward: division state.
    logic [15:0] den_sh;
    dstage_t     dst_init;
    dstage_t     dst_reg [DIV_STAGE+1];
    dstage_t     dst_next [DIV_STAGE+1];

    always_comb
    begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Magnitudes; the most negative numerator keeps magnitude 0x8000.
    assign mag0_next = in_data.f0[15] ? 16'd0 - in_data.f0 : in_data.f0;
    assign mag1_next = in_data.f1[15] ? 16'd0 - in_data.f1 : in_data.f1;

    // Right shift that brings the divisor below 256: the highest set bit wins.
    always_comb
    begin
        sh_next = 4'd0;
        for (int b = 8; b < QBITS; b++)
        begin
            if (in_data.f2[b])
            begin
                sh_next = 4'(b - 7);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mag0_reg <= mag0_next;
            mag1_reg <= mag1_next;
            den_reg  <= in_data.f2;
            sh_reg   <= sh_next;
            neg0_reg <= in_data.f0[15];
            neg1_reg <= in_data.f1[15];
            zero_reg <= (in_data.f2 == 16'd0);
            last_reg <= in_data.last;
        end
    end

    // Scale divisor and magnitudes together; division starts with no remainder.
    assign den_sh = den_reg >> sh_reg;

    always_comb
    begin
        dst_init.rem0 = 8'd0;
        dst_init.dq0  = mag0_reg >> sh_reg;
        dst_init.rem1 = 8'd0;
        dst_init.dq1  = mag1_reg >> sh_reg;
        dst_init.den  = den_sh[7:0];
        dst_init.neg0 = neg0_reg;
        dst_init.neg1 = neg1_reg;
        dst_init.zero = zero_reg;
        dst_init.last = last_reg;
    end

    assign dst_next[0] = dst_init;

    // Division stages, a few quotient bits per lane in each.
    for (genvar k = 1; k <= DIV_STAGE; k++)
    begin : g_div
        always_comb
        begin
            dst_next[k] = dst_reg[k-1];
            {dst_next[k].rem0, dst_next[k].dq0} =
                div_steps(dst_reg[k-1].rem0, dst_reg[k-1].dq0, dst_reg[k-1].den);
            {dst_next[k].rem1, dst_next[k].dq1} =
                div_steps(dst_reg[k-1].rem1, dst_reg[k-1].dq1, dst_reg[k-1].den);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STAGE; k++)
        begin
            if (rdy[k+1])
            begin
                dst_reg[k] <= dst_next[k];
            end
        end
    end

    assign out_valid      = v_reg[NSTAGE-1];
    assign out_data.qx    = dst_reg[DIV_STAGE].dq0[7:0];
    assign out_data.qy    = dst_reg[DIV_STAGE].dq1[7:0];
    assign out_data.neg_x = dst_reg[DIV_STAGE].neg0;
    assign out_data.neg_y = dst_reg[DIV_STAGE].neg1;
    assign out_data.zero  = dst_reg[DIV_STAGE].zero;
    assign out_data.last  = dst_reg[DIV_STAGE].last;

endmodule

@@ rtl/core/vertex_rotate_project.sv @@
// Top level of the vertex rotate and project pipeline with its output register.
//
//   Channel   Direction  Handshake                    Payload
//   vertex    in         vertex_valid / vertex_stall  vrp_pkg::vertex_t
//   point     out        point_valid / point_stall    vrp_pkg::point_t
//   config    in         cfg_write                    cfg_index, cfg_data
//
// One vertex is taken per clock while vertex_stall is low; its point is registered in
// four rotation stages, six divider stages and the output register before it is presented.
// The last four divider stages each resolve four quotient bits per lane.
// Reset clears the configuration and empties every stage; there is no clearing pass.
// A stalled output lets earlier stages fill up before vertex_stall rises.
module vertex_rotate_project
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vertex_valid,
    output logic                vertex_stall,
    input  vrp_pkg::vertex_t    vertex,
    output logic                point_valid,
    input  logic                point_stall,
    output vrp_pkg::point_t     point,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    vrp_pkg::coef_t  coef;
    vrp_pkg::xf_t    xf_data;
    vrp_pkg::quo_t   quo_data;
    logic            xf_valid;
    logic            xf_ready;
    logic            quo_valid;
    logic            quo_ready;
    logic            vertex_ready;

    logic            point_valid_reg;
    vrp_pkg::point_t point_reg;
    vrp_pkg::point_t point_next;
    logic [7:0]      qx_full;
    logic [7:0]      qy_full;
    logic [7:0]      px;
    logic [7:0]      py;

    vrp_coef u_coef
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    vrp_xform u_xform
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex_valid),
        .in_ready  (vertex_ready),
        .in_data   (vertex),
        .coef      (coef),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .out_data  (xf_data)
    );

    vrp_divide u_divide
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .in_ready  (xf_ready),
        .in_data   (xf_data),
        .out_valid (quo_valid),
        .out_ready (quo_ready),
        .out_data  (quo_data)
    );

    assign vertex_stall = !vertex_ready;

    // A zero divisor gives magnitude 0xFFFF, whose low byte is all ones.
    assign qx_full = quo_data.zero ? 8'hFF : quo_data.qx;
    assign qy_full = quo_data.zero ? 8'hFF : quo_data.qy;

    // Re-apply the numerator signs, then place the point around the centre.
    assign px = quo_data.neg_x ? 8'd0 - qx_full : qx_full;
    assign py = quo_data.neg_y ? 8'd0 - qy_full : qy_full;

    always_comb
    begin
        point_next.screen_x   = coef.center_x + px;
        point_next.screen_y   = coef.center_y - py;
        point_next.last_point = quo_data.last;
    end

    // Output register: loads whenever it is empty or its point is being taken.
    assign quo_ready = !point_valid_reg || !point_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid_reg <= 1'b0;
        end
        else if (quo_ready)
        begin
            point_valid_reg <= quo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quo_ready)
        begin
            point_reg <= point_next;
        end
    end

    assign point_valid = point_valid_reg;
    assign point       = point_reg;

`ifndef SYNTHESIS
    // The depth bias keeps the divisor positive, so the zero case never arrives.
    assert property (@(posedge clk) disable iff (!rst_n)
        quo_valid |-> !quo_data.zero)
        else $error("zero divisor reached the output stage");

    // Back-pressure on the input can only come from a held output point.
    assert property (@(posedge clk) disable iff (!rst_n)
        vertex_stall |-> (point_valid && point_stall))
        else $error("input stalled while the output was free");

    // A quotient moving into the open output register becomes a visible point.
    assert property (@(posedge clk) disable iff (!rst_n)
        (quo_valid && quo_ready) |=> point_valid)
        else $error("transfer into the output register was lost");
`endif

endmodule
